// ----- rtl/core/ogsr_pkg.sv -----
`timescale 1ns / 1ps

package ogsr_pkg;

  // Grid index and count width; it covers the full range of the grid parameters.
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int WORD_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS   = 2'd0,
    CFG_COLS   = 2'd1,
    CFG_MARGIN = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_RECT   = 3'd1,
    OP_CIRCLE = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_CLEAR,
    KIND_RECT,
    KIND_CIRC,
    KIND_READ,
    KIND_WRITE,
    KIND_NONE
  } kind_e;

  typedef enum logic [2:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_ROWINIT,
    BK_RD,
    BK_WAIT,
    BK_CELLS,
    BK_WR,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [14:0]        size_a;
    logic [14:0]        size_b;
    logic [7:0]         cell_row;
    logic [7:0]         cell_col;
    logic               cell_value;
  } in_word_t;

  typedef struct packed {
    logic cell_state;
    logic status;
  } out_word_t;

  // One classified command, handed from the front end to the back end.
  typedef struct packed {
    kind_e              kind;
    logic [CNT_W-1:0]   r0;
    logic [CNT_W-1:0]   r1;
    logic [CNT_W-1:0]   c0;
    logic [CNT_W-1:0]   c1;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [15:0]        big;
    logic [7:0]         row;
    logic [7:0]         col;
    logic               value;
    logic               status;
  } cmd_t;

  // Turns a bound in fractional cells into a cell index clipped to [0, count].
  function automatic logic [CNT_W-1:0] bound_idx(input logic signed [20:0] v,
                                                 input logic coarse,
                                                 input logic [CNT_W-1:0] count);
    logic signed [20:0] q;
    q = coarse ? (v >>> 5) : (v >>> 4);
    if (v <= 21'sd0) begin
      return '0;
    end else if (q > $signed({10'b0, count})) begin
      return count;
    end else begin
      return q[CNT_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/ogsr_ram.sv -----
`timescale 1ns / 1ps

module ogsr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ogsr_queue.sv -----
`timescale 1ns / 1ps

module ogsr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  // Two entries: enough for the front end to run one word ahead.
  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = slot_q[rd_ptr_q];

endmodule

// ----- rtl/core/ogsr_front.sv -----
`timescale 1ns / 1ps

module ogsr_front #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ogsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ogsr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ogsr_pkg::in_word_t                  in_word_i,
  input  logic                                q_full_i,
  input  logic                                sweeping_i,
  output logic                                push_o,
  output ogsr_pkg::cmd_t                      cmd_o,
  output logic                                clr_req_o
);

  logic [8:0]  rows_q, rows_d;
  logic [8:0]  cols_q, cols_d;
  logic [11:0] margin_q, margin_d;
  logic        clr_d;

  logic [ogsr_pkg::CNT_W-1:0] eff_rows, eff_cols;
  logic signed [20:0] cx_w, cy_w, sa_w, sb_w, m2_w, big_w;
  logic signed [20:0] rlo, rhi, clo, chi;
  logic               coarse;

  always_comb begin
    rows_d   = rows_q;
    cols_d   = cols_q;
    margin_d = margin_q;
    clr_d    = 1'b0;
    if (cfg_we_i) begin
      unique case (ogsr_pkg::cfg_reg_e'(cfg_idx_i))
        ogsr_pkg::CFG_ROWS: begin
          rows_d = cfg_data_i[8:0];
          clr_d  = cfg_data_i[8:0] != rows_q;
        end
        ogsr_pkg::CFG_COLS: begin
          cols_d = cfg_data_i[8:0];
          clr_d  = cfg_data_i[8:0] != cols_q;
        end
        ogsr_pkg::CFG_MARGIN: margin_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= 9'd256;
      cols_q    <= 9'd256;
      margin_q  <= '0;
      clr_req_o <= 1'b0;
    end else begin
      rows_q    <= rows_d;
      cols_q    <= cols_d;
      margin_q  <= margin_d;
      clr_req_o <= clr_d;
    end
  end

  always_comb begin
    eff_rows = ({2'b0, rows_q} > ogsr_pkg::CNT_W'(MAX_ROWS)) ? ogsr_pkg::CNT_W'(MAX_ROWS)
                                                           : {2'b0, rows_q};
    eff_cols = ({2'b0, cols_q} > ogsr_pkg::CNT_W'(MAX_COLS)) ? ogsr_pkg::CNT_W'(MAX_COLS)
                                                           : {2'b0, cols_q};
  end

  // Bounding box in fractional cells: 1/32 cell for rectangles, 1/16 for circles.
  always_comb begin
    cx_w  = 21'(in_word_i.center_x);
    cy_w  = 21'(in_word_i.center_y);
    sa_w  = $signed({6'b0, in_word_i.size_a});
    sb_w  = $signed({6'b0, in_word_i.size_b});
    m2_w  = $signed({8'b0, margin_q, 1'b0});
    big_w = sa_w + $signed({9'b0, margin_q});
    if (in_word_i.operation == ogsr_pkg::OP_RECT) begin
      coarse = 1'b1;
      rlo    = (cy_w <<< 1) - sb_w - m2_w;
      rhi    = (cy_w <<< 1) + sb_w + m2_w + 21'sd16;
      clo    = (cx_w <<< 1) - sa_w - m2_w;
      chi    = (cx_w <<< 1) + sa_w + m2_w + 21'sd16;
    end else begin
      coarse = 1'b0;
      rlo    = cy_w - big_w;
      rhi    = cy_w + big_w + 21'sd8;
      clo    = cx_w - big_w;
      chi    = cx_w + big_w + 21'sd8;
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.r0     = ogsr_pkg::bound_idx(rlo, coarse, eff_rows);
    cmd_o.r1     = ogsr_pkg::bound_idx(rhi, coarse, eff_rows);
    cmd_o.c0     = ogsr_pkg::bound_idx(clo, coarse, eff_cols);
    cmd_o.c1     = ogsr_pkg::bound_idx(chi, coarse, eff_cols);
    cmd_o.cx     = in_word_i.center_x;
    cmd_o.cy     = in_word_i.center_y;
    cmd_o.big    = big_w[15:0];
    cmd_o.row    = in_word_i.cell_row;
    cmd_o.col    = in_word_i.cell_col;
    cmd_o.value  = in_word_i.cell_value;
    cmd_o.status = 1'b0;
    cmd_o.kind   = ogsr_pkg::KIND_NONE;
    unique case (in_word_i.operation)
      ogsr_pkg::OP_CLEAR:  cmd_o.kind = ogsr_pkg::KIND_CLEAR;
      ogsr_pkg::OP_RECT:   cmd_o.kind = ogsr_pkg::KIND_RECT;
      ogsr_pkg::OP_CIRCLE: cmd_o.kind = ogsr_pkg::KIND_CIRC;
      ogsr_pkg::OP_READ, ogsr_pkg::OP_WRITE: begin
        if ({3'b0, in_word_i.cell_row} < eff_rows &&
            {3'b0, in_word_i.cell_col} < eff_cols) begin
          cmd_o.kind = (in_word_i.operation == ogsr_pkg::OP_READ) ? ogsr_pkg::KIND_READ
                                                                 : ogsr_pkg::KIND_WRITE;
        end else begin
          cmd_o.status = 1'b1;
        end
      end
      default: cmd_o.kind = ogsr_pkg::KIND_NONE;
    endcase
  end

  assign in_ready_o = !q_full_i && !sweeping_i;
  assign push_o     = in_valid_i && in_ready_o;

endmodule

// ----- rtl/core/ogsr_back.sv -----
`timescale 1ns / 1ps

module ogsr_back #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  ogsr_pkg::cmd_t        q_cmd_i,
  output logic                  q_pop_o,
  input  logic                  clr_req_i,
  output logic                  sweeping_o,
  output logic                  ram_we_o,
  output logic [(MAX_ROWS * ((MAX_COLS + 63) / 64) > 1 ?
                 $clog2(MAX_ROWS * ((MAX_COLS + 63) / 64)) : 1)-1:0] ram_waddr_o,
  output logic [ogsr_pkg::WORD_W-1:0] ram_wdata_o,
  output logic                  ram_re_o,
  output logic [(MAX_ROWS * ((MAX_COLS + 63) / 64) > 1 ?
                 $clog2(MAX_ROWS * ((MAX_COLS + 63) / 64)) : 1)-1:0] ram_raddr_o,
  input  logic [ogsr_pkg::WORD_W-1:0] ram_rdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ogsr_pkg::out_word_t   out_word_o
);

  localparam int ROW_WORDS = (MAX_COLS + 63) / 64;
  localparam int DEPTH     = MAX_ROWS * ROW_WORDS;
  localparam int AW        = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW        = ogsr_pkg::CNT_W;

  ogsr_pkg::bk_state_e state_q, state_d;
  ogsr_pkg::cmd_t      cmd_q, cmd_d;
  logic [CW-1:0]       row_q, row_d, col_q, col_d;
  logic [AW-1:0]       sweep_q, sweep_d, addr_q, addr_d;
  logic                fill_q, fill_d;
  logic                sweep_res_q, sweep_res_d;
  logic                clr_pend_q, clr_pend_d;
  logic [31:0]         lim_q, lim_d;
  logic signed [37:0]  dysq_q, dysq_d, dxsq_q, dxsq_d;
  logic signed [17:0]  dx_q, dx_d;
  logic [63:0]         word_q, word_d;
  logic                res_q, res_d;
  logic                out_valid_q, out_valid_d;
  ogsr_pkg::out_word_t out_q, out_d;

  logic               box_ok, cell_last, load_out, in_circle;
  logic [CW-1:0]      next_word_col;
  logic [AW-1:0]      cur_addr;
  logic signed [17:0] dy, dx0;
  logic [63:0]        rect_mask;

  always_comb begin
    box_ok        = q_cmd_i.r0 < q_cmd_i.r1 && q_cmd_i.c0 < q_cmd_i.c1;
    cell_last     = (col_q + CW'(1) == cmd_q.c1) || (col_q[5:0] == 6'h3f);
    next_word_col = {col_q[CW-1:6] + (CW-6)'(1), 6'b0};
    load_out      = !out_valid_q || out_ready_i;
    cur_addr      = AW'(int'(row_q) * ROW_WORDS + int'(col_q[CW-1:6]));
    dy            = $signed({3'b0, row_q, 4'b0}) - 18'(cmd_q.cy);
    dx0           = $signed({3'b0, col_q, 4'b0}) - 18'(cmd_q.cx);
    in_circle     = (dxsq_q + dysq_q) <= $signed({6'b0, lim_q});
    for (int b = 0; b < 64; b++) begin
      rect_mask[b] = ({col_q[CW-1:6], 6'(b)} >= cmd_q.c0) &&
                     ({col_q[CW-1:6], 6'(b)} < cmd_q.c1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ogsr_pkg::BK_SWEEP: begin
        if (sweep_q == AW'(DEPTH - 1)) begin
          state_d = sweep_res_q ? ogsr_pkg::BK_DONE : ogsr_pkg::BK_IDLE;
        end
      end
      ogsr_pkg::BK_IDLE: begin
        if (clr_pend_q) begin
          state_d = ogsr_pkg::BK_SWEEP;
        end else if (q_valid_i) begin
          unique case (q_cmd_i.kind)
            ogsr_pkg::KIND_CLEAR: state_d = ogsr_pkg::BK_SWEEP;
            ogsr_pkg::KIND_RECT:  state_d = box_ok ? ogsr_pkg::BK_RD : ogsr_pkg::BK_DONE;
            ogsr_pkg::KIND_CIRC:  state_d = box_ok ? ogsr_pkg::BK_ROWINIT
                                                   : ogsr_pkg::BK_DONE;
            ogsr_pkg::KIND_READ, ogsr_pkg::KIND_WRITE: state_d = ogsr_pkg::BK_RD;
            default: state_d = ogsr_pkg::BK_DONE;
          endcase
        end
      end
      ogsr_pkg::BK_ROWINIT: state_d = ogsr_pkg::BK_RD;
      ogsr_pkg::BK_RD:      state_d = ogsr_pkg::BK_WAIT;
      ogsr_pkg::BK_WAIT: begin
        unique case (cmd_q.kind)
          ogsr_pkg::KIND_CIRC: state_d = ogsr_pkg::BK_CELLS;
          ogsr_pkg::KIND_READ: state_d = ogsr_pkg::BK_DONE;
          default:             state_d = ogsr_pkg::BK_WR;
        endcase
      end
      ogsr_pkg::BK_CELLS: begin
        if (cell_last) begin
          state_d = ogsr_pkg::BK_WR;
        end
      end
      ogsr_pkg::BK_WR: begin
        unique case (cmd_q.kind)
          ogsr_pkg::KIND_RECT: begin
            if (next_word_col < cmd_q.c1 || row_q + CW'(1) < cmd_q.r1) begin
              state_d = ogsr_pkg::BK_RD;
            end else begin
              state_d = ogsr_pkg::BK_DONE;
            end
          end
          ogsr_pkg::KIND_CIRC: begin
            if (col_q < cmd_q.c1) begin
              state_d = ogsr_pkg::BK_RD;
            end else if (row_q + CW'(1) < cmd_q.r1) begin
              state_d = ogsr_pkg::BK_ROWINIT;
            end else begin
              state_d = ogsr_pkg::BK_DONE;
            end
          end
          default: state_d = ogsr_pkg::BK_DONE;
        endcase
      end
      ogsr_pkg::BK_DONE: begin
        if (load_out) begin
          state_d = ogsr_pkg::BK_IDLE;
        end
      end
      default: state_d = ogsr_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_d       = cmd_q;
    row_d       = row_q;
    col_d       = col_q;
    sweep_d     = sweep_q;
    addr_d      = addr_q;
    fill_d      = fill_q;
    sweep_res_d = sweep_res_q;
    clr_pend_d  = clr_pend_q | clr_req_i;
    lim_d       = lim_q;
    dysq_d      = dysq_q;
    dxsq_d      = dxsq_q;
    dx_d        = dx_q;
    word_d      = word_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q;
    ram_wdata_o = word_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = cur_addr;
    unique case (state_q)
      ogsr_pkg::BK_SWEEP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = sweep_q;
        ram_wdata_o = {64{fill_q}};
        sweep_d     = sweep_q + AW'(1);
      end
      ogsr_pkg::BK_IDLE: begin
        if (clr_pend_q) begin
          clr_pend_d  = clr_req_i;
          fill_d      = 1'b0;
          sweep_res_d = 1'b0;
          sweep_d     = '0;
        end else if (q_valid_i) begin
          q_pop_o     = 1'b1;
          cmd_d       = q_cmd_i;
          res_d       = 1'b0;
          lim_d       = q_cmd_i.big * q_cmd_i.big;
          fill_d      = 1'b1;
          sweep_res_d = 1'b1;
          sweep_d     = '0;
          if (q_cmd_i.kind == ogsr_pkg::KIND_READ || q_cmd_i.kind == ogsr_pkg::KIND_WRITE) begin
            row_d = {3'b0, q_cmd_i.row};
            col_d = {3'b0, q_cmd_i.col};
          end else begin
            row_d = q_cmd_i.r0;
            col_d = q_cmd_i.c0;
          end
        end
      end
      ogsr_pkg::BK_ROWINIT: begin
        dysq_d = 38'(dy * dy);
        dxsq_d = 38'(dx0 * dx0);
        dx_d   = dx0;
      end
      ogsr_pkg::BK_RD: begin
        ram_re_o = 1'b1;
        addr_d   = cur_addr;
      end
      ogsr_pkg::BK_WAIT: begin
        word_d = ram_rdata_i;
        unique case (cmd_q.kind)
          ogsr_pkg::KIND_RECT:  word_d = ram_rdata_i & ~rect_mask;
          ogsr_pkg::KIND_READ:  res_d  = ram_rdata_i[col_q[5:0]];
          ogsr_pkg::KIND_WRITE: word_d[col_q[5:0]] = cmd_q.value;
          default: ;
        endcase
      end
      ogsr_pkg::BK_CELLS: begin
        if (in_circle) begin
          word_d[col_q[5:0]] = 1'b0;
        end
        // (dx + 16)^2 = dx^2 + 32 dx + 256
        dxsq_d = dxsq_q + (38'(dx_q) <<< 5) + 38'sd256;
        dx_d   = dx_q + 18'sd16;
        col_d  = col_q + CW'(1);
      end
      ogsr_pkg::BK_WR: begin
        ram_we_o = 1'b1;
        if (cmd_q.kind == ogsr_pkg::KIND_RECT) begin
          if (next_word_col < cmd_q.c1) begin
            col_d = next_word_col;
          end else begin
            row_d = row_q + CW'(1);
            col_d = cmd_q.c0;
          end
        end else if (cmd_q.kind == ogsr_pkg::KIND_CIRC && col_q >= cmd_q.c1) begin
          row_d = row_q + CW'(1);
          col_d = cmd_q.c0;
        end
      end
      ogsr_pkg::BK_DONE: begin
        if (load_out) begin
          out_valid_d      = 1'b1;
          out_d.cell_state = res_q;
          out_d.status     = cmd_q.status;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ogsr_pkg::BK_SWEEP;
      sweep_q     <= '0;
      fill_q      <= 1'b0;
      sweep_res_q <= 1'b0;
      clr_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      fill_q      <= fill_d;
      sweep_res_q <= sweep_res_d;
      clr_pend_q  <= clr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    row_q  <= row_d;
    col_q  <= col_d;
    addr_q <= addr_d;
    lim_q  <= lim_d;
    dysq_q <= dysq_d;
    dxsq_q <= dxsq_d;
    dx_q   <= dx_d;
    word_q <= word_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign sweeping_o  = state_q == ogsr_pkg::BK_SWEEP;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- rtl/core/occupancy_grid_shape_rasterizer_unit.sv -----
`timescale 1ns / 1ps
// Channel  | Signals                              | Direction
// in       | in_valid_i, in_ready_o, in_word_i    | item into the block
// out      | out_valid_o, out_ready_i, out_word_o | one result word per item
// config   | cfg_we_i, cfg_idx_i, cfg_data_i      | register write, no wait
//
// From the queue a read passes RD, WAIT and DONE, a write also WR; an empty shape or an
// unknown code goes straight to DONE. A rectangle reads, masks and writes back each
// touched 64-bit row word; a circle starts each row in ROWINIT and tests the cells of
// each touched word in CELLS before the write-back. A clear, a changed row or column
// count, and reset sweep the whole grid memory, MAX_ROWS * ceil(MAX_COLS / 64) words,
// with in_ready_o low. The read-modify-write of one grid word at a time sets the rate.

module occupancy_grid_shape_rasterizer_unit #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ogsr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ogsr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ogsr_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ogsr_pkg::out_word_t             out_word_o
);

  localparam int ROW_WORDS = (MAX_COLS + 63) / 64;
  localparam int DEPTH     = MAX_ROWS * ROW_WORDS;
  localparam int AW        = DEPTH > 1 ? $clog2(DEPTH) : 1;

  // The front end classifies each word and computes its clipped bounding box;
  // the queue lets it run ahead of the back end, which walks the grid memory.
  logic           push, q_full, q_valid, q_pop, sweeping, clr_req;
  ogsr_pkg::cmd_t cmd_in, cmd_out;

  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [ogsr_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;

  ogsr_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .sweeping_i (sweeping),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .clr_req_o  (clr_req)
  );

  ogsr_queue #(
    .WIDTH($bits(ogsr_pkg::cmd_t))
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  ogsr_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (cmd_out),
    .q_pop_o     (q_pop),
    .clr_req_i   (clr_req),
    .sweeping_o  (sweeping),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // One 64-bit word per row slice; bit c%64 of word c/64 holds column c.
  ogsr_ram #(
    .WIDTH(ogsr_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- rtl/core/ogsr_checker.sv -----
`timescale 1ns / 1ps

module ogsr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ogsr_pkg::out_word_t out_word_o
);

  // A result word waiting on the consumer holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // A cell value is only reported for an in-range read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.cell_state && out_word_o.status))
    else $error("cell state reported with out-of-range status");

  // The grid sweep after reset keeps the input closed.
  assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !in_ready_o)
    else $error("input open during reset sweep");

  // No result appears before an item could have been taken.
  assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind occupancy_grid_shape_rasterizer_unit ogsr_checker u_checker (.*);

// ----- tb/occupancy_grid_shape_rasterizer_unit_tb.sv -----
`timescale 1ns / 1ps

module occupancy_grid_shape_rasterizer_unit_tb;
  import ogsr_pkg::*;

  localparam int GRID_ROWS = 256;
  localparam int GRID_COLS = 256;
  // The longest silent stretch is a circle filling the whole grid while the receiver stalls.
  localparam int QUIET_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;

  // The shadow grid, its registers and the queue of result words still owed by the block.
  class grid_scoreboard;
    bit [GRID_COLS-1:0] cells [GRID_ROWS];
    int unsigned rows_reg;
    int unsigned cols_reg;
    int unsigned margin_reg;
    out_word_t owed_words[$];
    int mismatches;

    function new();
      rows_reg = 256;
      cols_reg = 256;
      margin_reg = 0;
      mismatches = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function int rows_eff();
      return rows_reg > GRID_ROWS ? GRID_ROWS : rows_reg;
    endfunction

    function int cols_eff();
      return cols_reg > GRID_COLS ? GRID_COLS : cols_reg;
    endfunction

    // A size change wipes the grid to occupied; rewriting the same size does not.
    function void write_reg(cfg_reg_e idx, int unsigned value);
      int unsigned v;
      v = value & 9'h1FF;
      if (idx == CFG_ROWS || idx == CFG_COLS) begin
        if ((idx == CFG_ROWS ? rows_reg : cols_reg) != v) begin
          if (idx == CFG_ROWS) rows_reg = v;
          else cols_reg = v;
          foreach (cells[i]) cells[i] = '0;
        end
      end else if (idx == CFG_MARGIN) begin
        margin_reg = value & 12'hFFF;
      end
    endfunction

    // A bound in fractional cells becomes a cell index clipped to [0, count].
    function int clip_idx(longint v, int shift, int count);
      longint q;
      if (v <= 0) return 0;
      q = v >>> shift;
      return q > count ? count : int'(q);
    endfunction

    function void note_input(in_word_t w);
      longint cx, cy, sa, sb, m2, big, lim, dx, dy;
      int r0, r1, c0, c1, nr, nc;
      out_word_t res;
      cx = w.center_x;
      cy = w.center_y;
      sa = w.size_a;
      sb = w.size_b;
      nr = rows_eff();
      nc = cols_eff();
      res = '0;
      if (w.operation == OP_CLEAR) begin
        foreach (cells[i]) cells[i] = '1;
      end else if (w.operation == OP_RECT) begin
        // Rectangle bounds are kept in 1/32 cell so that the half width stays exact.
        m2 = 2 * longint'(margin_reg);
        r0 = clip_idx(2 * cy - sb - m2, 5, nr);
        r1 = clip_idx(2 * cy + sb + m2 + 16, 5, nr);
        c0 = clip_idx(2 * cx - sa - m2, 5, nc);
        c1 = clip_idx(2 * cx + sa + m2 + 16, 5, nc);
        for (int r = r0; r < r1; r++)
          for (int c = c0; c < c1; c++) cells[r][c] = 1'b0;
      end else if (w.operation == OP_CIRCLE) begin
        big = sa + longint'(margin_reg);
        lim = big * big;
        r0 = clip_idx(cy - big, 4, nr);
        r1 = clip_idx(cy + big + 8, 4, nr);
        c0 = clip_idx(cx - big, 4, nc);
        c1 = clip_idx(cx + big + 8, 4, nc);
        for (int r = r0; r < r1; r++) begin
          dy = 16 * longint'(r) - cy;
          for (int c = c0; c < c1; c++) begin
            dx = 16 * longint'(c) - cx;
            if (dx * dx + dy * dy <= lim) cells[r][c] = 1'b0;
          end
        end
      end else if (w.operation == OP_READ || w.operation == OP_WRITE) begin
        if (w.cell_row < nr && w.cell_col < nc) begin
          if (w.operation == OP_READ) res.cell_state = cells[w.cell_row][w.cell_col];
          else cells[w.cell_row][w.cell_col] = w.cell_value;
        end else begin
          res.status = 1'b1;
        end
      end
      owed_words.push_back(res);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %b", got);
        return;
      end
      want = owed_words.pop_front();
      if (got.cell_state !== want.cell_state || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: cell_state %b/%b status %b/%b (expected/actual)",
                   want.cell_state, got.cell_state, want.status, got.status);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_word_t              in_word_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_word_t             out_word_o;

  grid_scoreboard grid_sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles = 0;

  occupancy_grid_shape_rasterizer_unit #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The receiver stalls at random; the stall rate changes from phase to phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Handshakes are sampled at the edge, so both sides see the values from before it.
  // The output is checked first, since its word belongs to an earlier item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) grid_sb.check_result(out_word_o);
      if (in_valid_i && in_ready_o) grid_sb.note_input(in_word_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Register writes happen only after a drain, once all owed results are in, so the shadow copy is updated at once.
  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_sb.write_reg(idx, value);
  endtask

  // Offers one word, with an optional idle gap before it. Valid stays high between
  // back-to-back words, so it is never lowered and raised in the same step.
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Waits until every owed result has come, then lets the block finish any write-back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (grid_sb.owed_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_word_t make_word(logic [2:0] op, int cx, int cy, int sa, int sb,
                                         int row, int col, bit value);
    in_word_t w;
    w.operation  = op;
    w.center_x   = 16'(cx);
    w.center_y   = 16'(cy);
    w.size_a     = 15'(sa);
    w.size_b     = 15'(sb);
    w.cell_row   = 8'(row);
    w.cell_col   = 8'(col);
    w.cell_value = value;
    return w;
  endfunction

  // Random word. Most shapes sit near the grid and stay small; the rest is noise.
  // Huge circles test every cell of their box in turn, so they are only let loose on small grids.
  function automatic in_word_t random_word();
    in_word_t w;
    logic [95:0] raw;
    int pick, nr, nc;
    bit tidy;
    nr = grid_sb.rows_eff();
    nc = grid_sb.cols_eff();
    raw = {$urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    tidy = ($urandom_range(99) < 85);
    pick = $urandom_range(99);
    if (pick < 4) begin
      w.operation = OP_CLEAR;
    end else if (pick < 30 || pick < 55) begin
      w.operation = (pick < 30) ? OP_RECT : OP_CIRCLE;
      if (tidy) begin
        w.center_x = 16'($urandom_range(0, nc * 16 + 64) - 32);
        w.center_y = 16'($urandom_range(0, nr * 16 + 64) - 32);
        w.size_a   = 15'($urandom_range(0, (pick < 30) ? 128 : 48));
        w.size_b   = 15'($urandom_range(0, 128));
      end else if (pick >= 30 && nr * nc > 1024) begin
        w.size_a = 15'($urandom_range(0, 255));
      end
    end else if (pick < 95) begin
      w.operation = (pick < 75) ? OP_READ : OP_WRITE;
      if (tidy && nr > 0 && nc > 0) begin
        w.cell_row = 8'($urandom_range(0, nr - 1));
        w.cell_col = 8'($urandom_range(0, nc - 1));
      end
    end else begin
      // Codes past the last operation are ignored by the block.
      w.operation = 3'(OP_WRITE) + 3'($urandom_range(1, 3));
    end
    return w;
  endfunction

  int phase_rows   [8] = '{256, 16, 1, 511, 8, 0, 200, 256};
  int phase_cols   [8] = '{256, 100, 1, 511, 8, 64, 300, 256};
  int phase_margin [8] = '{0, 20, 4095, 7, 4095, 3, 0, 1};
  int phase_mode   [8] = '{0, 1, 2, 3, 1, 2, 3, 0};
  int phase_items  [8] = '{300, 250, 150, 250, 150, 80, 200, 70};

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_ROWS;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    in_word_i      <= '0;
    out_ready_i    <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset sizes: cell access at the corners, shapes at the
    // extremes of their fields, a shape wholly off the grid, and the unused codes.
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0, 1'b0));
    send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 255, 255, 1'b0));
    send_word(make_word(OP_WRITE, 0, 0, 0, 0, 3, 4, 1'b0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 3, 4, 1'b1));
    send_word(make_word(OP_WRITE, 0, 0, 0, 0, 255, 255, 1'b1));
    send_word(make_word(OP_RECT, 160, 160, 48, 32, 0, 0, 1'b0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 10, 10, 1'b0));
    send_word(make_word(OP_CIRCLE, 1024, 512, 32, 0, 0, 0, 1'b0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 32, 64, 1'b0));
    send_word(make_word(OP_CIRCLE, -32768, -32768, 0, 0, 0, 0, 1'b0));
    send_word(make_word(OP_RECT, -32768, -32768, 0, 0, 0, 0, 1'b0));
    send_word(make_word(OP_RECT, 0, 0, 0, 0, 0, 0, 1'b0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0, 1'b0));
    send_word(make_word(OP_RECT, 32767, 32767, 32767, 32767, 0, 0, 1'b0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 255, 0, 1'b0));
    send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
    send_word(make_word(OP_CIRCLE, 2048, 2048, 32767, 0, 0, 0, 1'b0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 255, 1'b0));
    for (int k = 1; k <= 3; k++)
      send_word(make_word(3'(OP_WRITE) + 3'(k), 0, 0, 0, 0, 0, 0, 1'b1));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 128, 128, 1'b0));
    drain();

    // Random phases, each with its own sizes, margin and idling pattern.
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_ROWS, phase_rows[p]);
      write_reg(CFG_COLS, phase_cols[p]);
      write_reg(CFG_MARGIN, phase_margin[p]);
      case (phase_mode[p])
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 65;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 65;
        end
        default: begin
          send_idle_pct = 24;
          recv_stall_pct = 24;
        end
      endcase
      // A clear now and then keeps enough free cells around for reads to see both values.
      send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
      for (int i = 0; i < phase_items[p]; i++) send_word(random_word());
      drain();
    end

    if (grid_sb.mismatches == 0 && grid_sb.owed_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
